// ===== src/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, codes, saturation and magnitude helpers for the LU pivot linear solver.
// ----------------------------------------------------------------------------
package lps_pkg;

    // Item operation codes
    localparam logic [1:0] OP_LOAD_MAT = 2'd0;
    localparam logic [1:0] OP_LOAD_RHS = 2'd1;
    localparam logic [1:0] OP_SOLVE    = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_THRESHOLD = 1'b1;
    localparam int CFG_DATA_W = 31;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Matrix write data source
    typedef enum logic [1:0] {
        WSRC_RES    = 2'd0,
        WSRC_SWAP_A = 2'd1,
        WSRC_SWAP_B = 2'd2
    } lps_wsrc_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_mat;
        logic      load_rhs;
        logic      ord_init;
        logic      ord_swap;
        logic      mat_rd;
        logic      sol_rd;
        logic      rhs_rd;
        logic      mul;
        logic      acc_clr;
        logic      acc_add;
        logic      b_from_sol;
        logic      base_from_sol;
        logic      piv_take;
        logic      div_start;
        logic      div_by_piv;
        logic      res_from_div;
        logic      mat_wr;
        lps_wsrc_t mat_src;
        logic      sol_wr;
        logic      sol_copy;
        logic      out_load;
        logic      out_singular;
        logic      out_last;
    } lps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic better;
        logic singular;
        logic div_done;
    } lps_stat_t;

    // Saturate a 33-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude of a signed word as an unsigned word
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

// ===== src/lps_if.sv =====
// ----------------------------------------------------------------------------
// lps_if
// Valid/ready channels for load/solve items and solution results.
// ----------------------------------------------------------------------------
interface lps_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;

    modport source (output valid, output op, output row, output col, output value,
                    input ready);
    modport sink (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

interface lps_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               status;
    logic               last;

    modport source (output valid, output index, output solution, output status,
                    output last, input ready);
    modport sink (input valid, input index, input solution, input status,
                  input last, output ready);
endinterface

// ===== src/lps_divider.sv =====
// ----------------------------------------------------------------------------
// lps_divider
// Bit-serial signed Q divider: (num << FRAC_BITS) / den, truncated and saturated.
// ----------------------------------------------------------------------------
module lps_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    import lps_pkg::*;

    localparam int NW   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   dq_reg,  dq_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     dv_reg,  dv_next;
    logic            neg_reg, neg_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [32:0]     rem_sh;
    logic [32:0]     rem_sub;

    // One quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg[31:0], dq_reg[NW-1]};
        rem_sub  = rem_sh - {1'b0, dv_reg};
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dv_next  = dv_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = {mag32(num), {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dv_next   = mag32(den);
            neg_next  = num[31] ^ den[31];
            cnt_next  = CNTW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dv_reg})
            begin
                rem_next = rem_sub;
                dq_next  = {dq_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dq_next  = {dq_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        neg_reg <= neg_next;
    end

    // Apply sign and saturate
    always_comb
    begin
        if (!neg_reg)
        begin
            quo = (dq_reg > NW'(32'h7FFF_FFFF)) ? Q_MAX : dq_reg[31:0];
        end
        else
        begin
            quo = (dq_reg > NW'(33'h0_8000_0000)) ? Q_MIN : (~dq_reg[31:0] + 32'd1);
        end
    end

    assign done = done_reg;

endmodule

// ===== src/lps_datapath.sv =====
// ----------------------------------------------------------------------------
// lps_datapath
// Matrix, rhs and solution stores, multiply-accumulate, pivot tracking,
// divider and result register.
// ----------------------------------------------------------------------------
module lps_datapath #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lps_pkg::lps_cmd_t                     cmd,
    input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] a_row,
    input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] a_col,
    input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_row,
    input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_col,
    input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] w_row,
    input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] w_col,
    input  logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] s_addr,
    input  logic [3:0]                            ld_row,
    input  logic [3:0]                            ld_col,
    input  logic signed [31:0]                    ld_value,
    input  logic [30:0]                           thr,
    output lps_pkg::lps_stat_t                    stat,
    output logic [3:0]                            res_index,
    output logic signed [31:0]                    res_solution,
    output logic                                  res_status,
    output logic                                  res_last
);
    import lps_pkg::*;

    localparam int IW    = MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic signed [31:0] mat_mem [DEPTH];
    logic signed [31:0] rhs_mem [MAX_SIZE];
    logic signed [31:0] sol_mem [MAX_SIZE];
    logic [IW-1:0]      ord_reg [MAX_SIZE];

    logic signed [31:0] rda_reg, rdb_reg, sol_rd_reg, rhs_rd_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic [31:0]        big_reg;
    logic signed [31:0] piv_reg;
    logic [3:0]         out_index_reg;
    logic signed [31:0] out_sol_reg;
    logic               out_status_reg, out_last_reg;

    logic [AW-1:0]      addr_a, addr_b, addr_w, addr_ld;
    logic               ld_in_range;
    logic signed [31:0] opb, base, diff_w, qm, sum_w, res, div_quo, mat_wdata;
    logic signed [63:0] prod_sh;
    logic               div_done;

    function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(r) * AW'(MAX_SIZE) + AW'(c);
    endfunction

    assign addr_a  = mat_addr(a_row, a_col);
    assign addr_b  = mat_addr(b_row, b_col);
    assign addr_w  = mat_addr(w_row, w_col);
    assign addr_ld = mat_addr(IW'(ld_row), IW'(ld_col));
    assign ld_in_range = (32'(ld_row) < MAX_SIZE) && (32'(ld_col) < MAX_SIZE);

    // Arithmetic: floor product, saturating sums
    assign opb     = cmd.b_from_sol ? sol_rd_reg : rdb_reg;
    assign base    = cmd.base_from_sol ? sol_rd_reg : rda_reg;
    assign diff_w  = sat33({base[31], base} - {acc_reg[31], acc_reg});
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign qm      = (prod_sh > 64'sh7FFF_FFFF) ? Q_MAX :
                     (prod_sh < -64'sh8000_0000) ? Q_MIN : prod_sh[31:0];
    assign sum_w   = sat33({acc_reg[31], acc_reg} + {qm[31], qm});
    assign res     = cmd.res_from_div ? div_quo : diff_w;

    lps_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (diff_w),
        .den   (cmd.div_by_piv ? piv_reg : rdb_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        unique case (cmd.mat_src)
            WSRC_SWAP_A: mat_wdata = rda_reg;
            WSRC_SWAP_B: mat_wdata = rdb_reg;
            default:     mat_wdata = res;
        endcase
    end

    // Matrix store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load_mat && ld_in_range)
        begin
            mat_mem[addr_ld] <= ld_value;
        end
        else if (cmd.mat_wr)
        begin
            mat_mem[addr_w] <= mat_wdata;
        end
        if (cmd.mat_rd)
        begin
            rda_reg <= mat_mem[addr_a];
            rdb_reg <= mat_mem[addr_b];
        end
    end

    // Right-hand side store, read through the row order
    always_ff @(posedge clk)
    begin
        if (cmd.load_rhs && (32'(ld_row) < MAX_SIZE))
        begin
            rhs_mem[IW'(ld_row)] <= ld_value;
        end
        if (cmd.rhs_rd)
        begin
            rhs_rd_reg <= rhs_mem[ord_reg[s_addr]];
        end
    end

    // Solution store
    always_ff @(posedge clk)
    begin
        if (cmd.sol_wr)
        begin
            sol_mem[s_addr] <= cmd.sol_copy ? rhs_rd_reg : res;
        end
        if (cmd.sol_rd)
        begin
            sol_rd_reg <= sol_mem[s_addr];
        end
    end

    // Row order: identity at reset and solve start, swap on pivot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_SIZE; r++)
            begin
                ord_reg[r] <= IW'(r);
            end
        end
        else if (cmd.ord_init)
        begin
            for (int r = 0; r < MAX_SIZE; r++)
            begin
                ord_reg[r] <= IW'(r);
            end
        end
        else if (cmd.ord_swap)
        begin
            ord_reg[a_row] <= ord_reg[b_row];
            ord_reg[b_row] <= ord_reg[a_row];
        end
    end

    // Multiply-accumulate and pivot registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= 64'(rda_reg) * 64'(opb);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= sum_w;
        end
        if (cmd.piv_take)
        begin
            big_reg <= mag32(rda_reg);
            piv_reg <= rda_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg  <= cmd.out_singular ? 4'd0 : 4'(s_addr);
            out_sol_reg    <= cmd.out_singular ? 32'sd0 : sol_rd_reg;
            out_status_reg <= cmd.out_singular;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign stat.better   = mag32(rda_reg) > big_reg;
    assign stat.singular = big_reg <= {1'b0, thr};
    assign stat.div_done = div_done;

    assign res_index    = out_index_reg;
    assign res_solution = out_sol_reg;
    assign res_status   = out_status_reg;
    assign res_last     = out_last_reg;

endmodule

// ===== src/lps_control.sv =====
// ----------------------------------------------------------------------------
// lps_control
// Sequencer for loads, Crout factorisation with pivoting, substitution and
// result transfer.
// ----------------------------------------------------------------------------
module lps_control #(
    parameter int MAX_SIZE = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    input  logic [1:0]                            item_op,
    output logic                                  item_ready,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    input  logic [4:0]                            size,
    input  lps_pkg::lps_stat_t                    stat,
    output lps_pkg::lps_cmd_t                     cmd,
    output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] a_row,
    output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] a_col,
    output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_row,
    output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] b_col,
    output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] w_row,
    output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] w_col,
    output logic [(MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1)-1:0] s_addr
);
    import lps_pkg::*;

    localparam int IW = MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1;
    localparam int CW = $clog2(MAX_SIZE + 1);

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_INIT  = 21'h000002,
        S_JST   = 21'h000004,
        S_PRD   = 21'h000008,
        S_PCMP  = 21'h000010,
        S_PCHK  = 21'h000020,
        S_SWRD  = 21'h000040,
        S_SWW1  = 21'h000080,
        S_SWW2  = 21'h000100,
        S_TRD   = 21'h000200,
        S_TMUL  = 21'h000400,
        S_TACC  = 21'h000800,
        S_BRD   = 21'h001000,
        S_BSUB  = 21'h002000,
        S_DIVW  = 21'h004000,
        S_NEXT  = 21'h008000,
        S_CRD   = 21'h010000,
        S_CWR   = 21'h020000,
        S_ORD   = 21'h040000,
        S_OLOAD = 21'h080000,
        S_OWAIT = 21'h100000
    } state_t;

    typedef enum logic [1:0] {
        PH_L   = 2'd0,
        PH_U   = 2'd1,
        PH_FWD = 2'd2,
        PH_BWD = 2'd3
    } phase_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, n_reg, n_next;
    logic [CW-1:0] best_reg, best_next;
    logic          outv_reg, outv_next, fin_reg, fin_next;
    logic [CW-1:0] klim, i_inc, k_inc, j_inc;
    logic          fsub;

    assign i_inc = i_reg + CW'(1);
    assign k_inc = k_reg + CW'(1);
    assign j_inc = j_reg + CW'(1);
    assign fsub  = (phase_reg == PH_FWD) || (phase_reg == PH_BWD);

    // Term index limit of the current element
    always_comb
    begin
        unique case (phase_reg)
            PH_L, PH_U: klim = j_reg;
            PH_FWD:     klim = i_reg;
            default:    klim = n_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        best_next  = best_reg;
        outv_next  = outv_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        a_row      = '0;
        a_col      = '0;
        b_row      = '0;
        b_col      = '0;
        w_row      = '0;
        w_col      = '0;
        s_addr     = '0;

        unique case (state_reg)
            // Take loads directly; start a solve
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item_op)
                        OP_LOAD_MAT: cmd.load_mat = 1'b1;
                        OP_LOAD_RHS: cmd.load_rhs = 1'b1;
                        OP_SOLVE:
                        begin
                            if (size == 5'd0)
                            begin
                                n_next = CW'(1);
                            end
                            else if (32'(size) > MAX_SIZE)
                            begin
                                n_next = CW'(MAX_SIZE);
                            end
                            else
                            begin
                                n_next = CW'(size);
                            end
                            state_next = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.ord_init = 1'b1;
                j_next       = '0;
                state_next   = S_JST;
            end
            // Column start: L column first unless at column zero
            S_JST:
            begin
                cmd.acc_clr = 1'b1;
                i_next      = j_reg;
                k_next      = '0;
                if (j_reg == '0)
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    phase_next = PH_L;
                    state_next = S_TRD;
                end
            end
            // Pivot search down the column
            S_PRD:
            begin
                cmd.mat_rd = 1'b1;
                a_row      = IW'(i_reg);
                a_col      = IW'(j_reg);
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                if ((i_reg == j_reg) || stat.better)
                begin
                    cmd.piv_take = 1'b1;
                    best_next    = i_reg;
                end
                if (i_inc < n_reg)
                begin
                    i_next     = i_inc;
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                if (stat.singular)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_singular = 1'b1;
                    cmd.out_last     = 1'b1;
                    outv_next        = 1'b1;
                    fin_next         = 1'b1;
                    state_next       = S_OWAIT;
                end
                else if (best_reg != j_reg)
                begin
                    cmd.ord_swap = 1'b1;
                    a_row        = IW'(j_reg);
                    b_row        = IW'(best_reg);
                    state_next   = S_SWRD;
                end
                else if (j_inc < n_reg)
                begin
                    phase_next = PH_U;
                    i_next     = j_inc;
                    state_next = S_TRD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_CRD;
                end
            end
            // Row swap, one column at a time
            S_SWRD:
            begin
                cmd.mat_rd = 1'b1;
                a_row      = IW'(j_reg);
                a_col      = IW'(k_reg);
                b_row      = IW'(best_reg);
                b_col      = IW'(k_reg);
                state_next = S_SWW1;
            end
            S_SWW1:
            begin
                cmd.mat_wr  = 1'b1;
                cmd.mat_src = WSRC_SWAP_B;
                w_row       = IW'(j_reg);
                w_col       = IW'(k_reg);
                state_next  = S_SWW2;
            end
            S_SWW2:
            begin
                cmd.mat_wr  = 1'b1;
                cmd.mat_src = WSRC_SWAP_A;
                w_row       = IW'(best_reg);
                w_col       = IW'(k_reg);
                if (k_inc < n_reg)
                begin
                    k_next     = k_inc;
                    state_next = S_SWRD;
                end
                else
                begin
                    k_next = '0;
                    if (j_inc < n_reg)
                    begin
                        phase_next = PH_U;
                        i_next     = j_inc;
                        state_next = S_TRD;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = S_CRD;
                    end
                end
            end
            // Dot product terms
            S_TRD:
            begin
                a_row  = IW'((phase_reg == PH_U) ? j_reg : i_reg);
                a_col  = IW'(k_reg);
                b_row  = IW'(k_reg);
                b_col  = IW'((phase_reg == PH_L) ? j_reg : i_reg);
                s_addr = IW'(k_reg);
                if (k_reg < klim)
                begin
                    cmd.mat_rd = 1'b1;
                    cmd.sol_rd = fsub;
                    state_next = S_TMUL;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end
            S_TMUL:
            begin
                cmd.mul        = 1'b1;
                cmd.b_from_sol = fsub;
                state_next     = S_TACC;
            end
            S_TACC:
            begin
                cmd.acc_add = 1'b1;
                k_next      = k_inc;
                state_next  = S_TRD;
            end
            // Base value and divisor
            S_BRD:
            begin
                a_row      = IW'((phase_reg == PH_U) ? j_reg : i_reg);
                a_col      = IW'((phase_reg == PH_U) ? i_reg : j_reg);
                b_row      = IW'(i_reg);
                b_col      = IW'(i_reg);
                s_addr     = IW'(i_reg);
                cmd.mat_rd = (phase_reg != PH_BWD);
                cmd.sol_rd = fsub;
                state_next = S_BSUB;
            end
            S_BSUB:
            begin
                cmd.base_from_sol = fsub;
                w_row             = IW'(i_reg);
                w_col             = IW'(j_reg);
                s_addr            = IW'(i_reg);
                unique case (phase_reg)
                    PH_L:
                    begin
                        cmd.mat_wr = 1'b1;
                        state_next = S_NEXT;
                    end
                    PH_BWD:
                    begin
                        cmd.sol_wr = 1'b1;
                        state_next = S_NEXT;
                    end
                    default:
                    begin
                        cmd.div_start  = 1'b1;
                        cmd.div_by_piv = (phase_reg == PH_U);
                        state_next     = S_DIVW;
                    end
                endcase
            end
            S_DIVW:
            begin
                cmd.res_from_div = 1'b1;
                w_row            = IW'(j_reg);
                w_col            = IW'(i_reg);
                s_addr           = IW'(i_reg);
                if (stat.div_done)
                begin
                    cmd.mat_wr = (phase_reg == PH_U);
                    cmd.sol_wr = (phase_reg == PH_FWD);
                    state_next = S_NEXT;
                end
            end
            // Advance to the next element or phase
            S_NEXT:
            begin
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                unique case (phase_reg)
                    PH_L:
                    begin
                        if (i_inc < n_reg)
                        begin
                            i_next     = i_inc;
                            state_next = S_TRD;
                        end
                        else
                        begin
                            i_next     = j_reg;
                            state_next = S_PRD;
                        end
                    end
                    PH_U:
                    begin
                        if (i_inc < n_reg)
                        begin
                            i_next     = i_inc;
                            state_next = S_TRD;
                        end
                        else
                        begin
                            j_next     = j_inc;
                            state_next = S_JST;
                        end
                    end
                    PH_FWD:
                    begin
                        if (i_inc < n_reg)
                        begin
                            i_next     = i_inc;
                            state_next = S_TRD;
                        end
                        else if (n_reg > CW'(1))
                        begin
                            phase_next = PH_BWD;
                            i_next     = n_reg - CW'(2);
                            k_next     = n_reg - CW'(1);
                            state_next = S_TRD;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = S_ORD;
                        end
                    end
                    default:
                    begin
                        if (i_reg != '0)
                        begin
                            i_next     = i_reg - CW'(1);
                            k_next     = i_reg;
                            state_next = S_TRD;
                        end
                        else
                        begin
                            state_next = S_ORD;
                        end
                    end
                endcase
            end
            // Permuted copy of the right-hand side
            S_CRD:
            begin
                cmd.rhs_rd = 1'b1;
                s_addr     = IW'(i_reg);
                state_next = S_CWR;
            end
            S_CWR:
            begin
                cmd.sol_wr   = 1'b1;
                cmd.sol_copy = 1'b1;
                s_addr       = IW'(i_reg);
                if (i_inc < n_reg)
                begin
                    i_next     = i_inc;
                    state_next = S_CRD;
                end
                else
                begin
                    cmd.acc_clr = 1'b1;
                    phase_next  = PH_FWD;
                    i_next      = '0;
                    k_next      = '0;
                    state_next  = S_TRD;
                end
            end
            // Emit solutions in index order
            S_ORD:
            begin
                cmd.sol_rd = 1'b1;
                s_addr     = IW'(i_reg);
                state_next = S_OLOAD;
            end
            S_OLOAD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_last = (i_inc == n_reg);
                s_addr       = IW'(i_reg);
                fin_next     = (i_inc == n_reg);
                outv_next    = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (result_ready)
                begin
                    outv_next = 1'b0;
                    if (fin_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_L;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            n_reg     <= CW'(1);
            best_reg  <= '0;
            outv_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            best_reg  <= best_next;
            outv_reg  <= outv_next;
            fin_reg   <= fin_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = outv_reg;

endmodule

// ===== src/lu_pivot_linear_solver.sv =====
// ----------------------------------------------------------------------------
// lu_pivot_linear_solver
// Solves A x = b in signed Q format by Crout LU factorisation with partial
// pivoting, forward and back substitution.
//
//   channel   direction  transfer carries
//   item      in         op, row, col, value (load entry or solve)
//   result    out        index, solution, status, last
//   cfg       in         write enable, register index, data (no read-back)
//
// Loads transfer one per cycle. A solve holds item.ready low until it returns
// to idle: every product term passes the read, multiply and accumulate states
// on the single multiply-accumulate path, and each of the n(n+1)/2
// divisions runs through a bit-serial divider of 32 + FRAC_BITS steps. Each
// result waits in an output register until its transfer; reset returns to
// idle with matrix_size 16, threshold 0 and identity row order, no clearing
// pass.
// ----------------------------------------------------------------------------
module lu_pivot_linear_solver #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data,
    lps_in_if.sink                           item,
    lps_out_if.source                        result
);
    import lps_pkg::*;

    localparam int IW = MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1;

    logic [4:0]    size_reg;
    logic [30:0]   thr_reg;
    lps_cmd_t      cmd;
    lps_stat_t     stat;
    logic [IW-1:0] a_row, a_col, b_row, b_col, w_row, w_col, s_addr;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 5'd16;
            thr_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MATRIX_SIZE)
            begin
                size_reg <= cfg_data[4:0];
            end
            else if (cfg_index == CFG_PIVOT_THRESHOLD)
            begin
                thr_reg <= cfg_data[30:0];
            end
        end
    end

    lps_control #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_op      (item.op),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .size         (size_reg),
        .stat         (stat),
        .cmd          (cmd),
        .a_row        (a_row),
        .a_col        (a_col),
        .b_row        (b_row),
        .b_col        (b_col),
        .w_row        (w_row),
        .w_col        (w_col),
        .s_addr       (s_addr)
    );

    lps_datapath #(
        .MAX_SIZE  (MAX_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .a_row        (a_row),
        .a_col        (a_col),
        .b_row        (b_row),
        .b_col        (b_col),
        .w_row        (w_row),
        .w_col        (w_col),
        .s_addr       (s_addr),
        .ld_row       (item.row),
        .ld_col       (item.col),
        .ld_value     (item.value),
        .thr          (thr_reg),
        .stat         (stat),
        .res_index    (result.index),
        .res_solution (result.solution),
        .res_status   (result.status),
        .res_last     (result.last)
    );

endmodule
